FILE: design/wall_follow_steering_classifier_defines.svh
// Assertion macros used by the checker file of the steering classifier.
`ifndef WALL_FOLLOW_STEERING_CLASSIFIER_DEFINES_SVH
`define WALL_FOLLOW_STEERING_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wfsc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wfsc check failed");

`endif

FILE: design/wfsc_pkg.sv
// Types and constants for the wall-follow steering classifier.
package wfsc_pkg;

    localparam int DIST_W  = 10;
    localparam int DRIVE_W = 12;
    localparam int CLASS_W = 3;

    localparam int HISTORY_DEPTH_DEFAULT = 5;

    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 10'd200;

    localparam logic signed [DRIVE_W-1:0] TWO_WALL_SPEED = 12'sd70;
    localparam logic [DIST_W:0]           SIDE_OFFSET    = 11'd40;
    localparam logic signed [DRIVE_W-1:0] SPIN_SPEED     = 12'sd50;

    // x/5 for x < 16384 as (x * 6554) >> 15
    localparam logic [12:0] DIV5_RECIP = 13'd6554;
    localparam int          DIV5_SHIFT = 15;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_FRONT = 3'd0,
        CLASS_TWO   = 3'd1,
        CLASS_LEFT  = 3'd2,
        CLASS_RIGHT = 3'd3,
        CLASS_NONE  = 3'd4
    } t_wall_class;

    // History update request from the pipeline control
    typedef struct packed {
        logic        advance;
        t_wall_class cls;
    } t_hist_req;

endpackage

FILE: design/wfsc_classify.sv
// Threshold compare, wall class and wheel speed computation.
module wfsc_classify
    import wfsc_pkg::*;
(
    input  logic [DIST_W-1:0]         i_threshold,
    input  logic [DIST_W-1:0]         i_left_distance,
    input  logic [DIST_W-1:0]         i_right_distance,
    input  logic [DIST_W-1:0]         i_front_distance,
    output t_wall_class               o_wall_class,
    output logic signed [DRIVE_W-1:0] o_left_drive,
    output logic signed [DRIVE_W-1:0] o_right_drive
);

    logic                      wall_l;
    logic                      wall_r;
    logic                      wall_f;
    logic [DIST_W:0]           side_base;
    logic signed [DRIVE_W-1:0] side_base_s;
    logic signed [DRIVE_W-1:0] left_s;
    logic signed [DRIVE_W-1:0] right_s;
    logic signed [DRIVE_W-1:0] base;
    logic signed [DRIVE_W-1:0] diff;
    logic signed [DRIVE_W:0]   twice;
    logic                      neg;
    logic [DRIVE_W-1:0]        mag;
    logic [24:0]               prod;
    logic [DRIVE_W-1:0]        quot;
    logic signed [DRIVE_W-1:0] weight;

    assign wall_l = i_left_distance  > i_threshold;
    assign wall_r = i_right_distance > i_threshold;
    assign wall_f = i_front_distance > i_threshold;

    assign side_base   = {1'b0, i_threshold} + SIDE_OFFSET;
    assign side_base_s = $signed({1'b0, side_base});
    assign left_s      = $signed({2'b00, i_left_distance});
    assign right_s     = $signed({2'b00, i_right_distance});

    always_comb begin
        if (wall_f) begin
            o_wall_class = CLASS_FRONT;
        end else if (wall_l && wall_r) begin
            o_wall_class = CLASS_TWO;
        end else if (wall_l) begin
            o_wall_class = CLASS_LEFT;
        end else if (wall_r) begin
            o_wall_class = CLASS_RIGHT;
        end else begin
            o_wall_class = CLASS_NONE;
        end
    end

    always_comb begin
        base = side_base_s;
        diff = '0;
        case (o_wall_class)
            CLASS_TWO: begin
                base = TWO_WALL_SPEED;
                diff = left_s - right_s;
            end
            CLASS_LEFT: begin
                diff = left_s - side_base_s;
            end
            CLASS_RIGHT: begin
                diff = side_base_s - right_s;
            end
            default: begin
                diff = '0;
            end
        endcase
    end

    // (2d)/5 truncated toward zero: divide the magnitude, restore the sign
    assign twice  = {diff, 1'b0};
    assign neg    = twice[DRIVE_W];
    assign mag    = neg ? DRIVE_W'(-twice) : DRIVE_W'(twice);
    assign prod   = mag * DIV5_RECIP;
    assign quot   = DRIVE_W'(prod >> DIV5_SHIFT);
    assign weight = neg ? -$signed(quot) : $signed(quot);

    always_comb begin
        case (o_wall_class)
            CLASS_FRONT: begin
                o_left_drive  = '0;
                o_right_drive = '0;
            end
            CLASS_NONE: begin
                o_left_drive  = -SPIN_SPEED;
                o_right_drive = SPIN_SPEED;
            end
            default: begin
                o_left_drive  = -(base + weight);
                o_right_drive = base - weight;
            end
        endcase
    end

endmodule

FILE: design/wfsc_history.sv
// Class history shift register and node detection.
module wfsc_history
    import wfsc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_hist_req i_req,
    output logic      o_node_entered
);

    t_wall_class r_hist [HISTORY_DEPTH];
    logic        r_primed;
    logic        stable;
    logic        node;

    // Entries 1..D-2 after the shift are old entries 0..D-3; oldest is old D-2
    always_comb begin
        stable = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH - 2; i++) begin
            if (r_hist[i] != i_req.cls) begin
                stable = 1'b0;
            end
        end
        node = (i_req.cls == CLASS_FRONT) ||
               (r_primed && stable && (r_hist[HISTORY_DEPTH-2] != i_req.cls));
    end

    assign o_node_entered = node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (i_req.advance) begin
            r_primed <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.advance) begin
            if (node || !r_primed) begin
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                    r_hist[i] <= i_req.cls;
                end
            end else begin
                r_hist[0] <= i_req.cls;
                for (int i = 1; i < HISTORY_DEPTH; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end
        end
    end

endmodule

FILE: design/wall_follow_steering_classifier.sv
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless stalled; input and result registers are two stages.
// Stall propagates back combinationally through the two stage enables.
// Reset (synchronous, active low) clears both valid flags, the primed flag and sets the
// threshold to 200; history entries are refilled by the first request.
module wall_follow_steering_classifier
    import wfsc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [DIST_W-1:0]         i_left_distance,
    input  logic [DIST_W-1:0]         i_right_distance,
    input  logic [DIST_W-1:0]         i_front_distance,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CLASS_W-1:0]        o_wall_class,
    output logic signed [DRIVE_W-1:0] o_left_drive,
    output logic signed [DRIVE_W-1:0] o_right_drive,
    output logic                      o_node_entered,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [DIST_W-1:0]         i_cfg_data
);

    logic [DIST_W-1:0]         r_threshold;
    logic                      r_s1_valid;
    logic [DIST_W-1:0]         r_s1_left;
    logic [DIST_W-1:0]         r_s1_right;
    logic [DIST_W-1:0]         r_s1_front;
    logic                      r_out_valid;
    t_wall_class               r_class;
    logic signed [DRIVE_W-1:0] r_left_drive;
    logic signed [DRIVE_W-1:0] r_right_drive;
    logic                      r_node;

    logic                      s2_ready;
    logic                      s1_ready;
    logic                      s1_move;
    t_wall_class               calc_class;
    logic signed [DRIVE_W-1:0] calc_left;
    logic signed [DRIVE_W-1:0] calc_right;
    logic                      calc_node;
    t_hist_req                 hist_req;

    assign s2_ready    = !r_out_valid || !i_out_stall;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign s1_move     = r_s1_valid && s2_ready;
    assign o_in_stall  = !s1_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_left  <= i_left_distance;
            r_s1_right <= i_right_distance;
            r_s1_front <= i_front_distance;
        end
    end

    wfsc_classify u_classify (
        .i_threshold      (r_threshold),
        .i_left_distance  (r_s1_left),
        .i_right_distance (r_s1_right),
        .i_front_distance (r_s1_front),
        .o_wall_class     (calc_class),
        .o_left_drive     (calc_left),
        .o_right_drive    (calc_right)
    );

    assign hist_req.advance = s1_move;
    assign hist_req.cls     = calc_class;

    wfsc_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (hist_req),
        .o_node_entered (calc_node)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_class       <= calc_class;
            r_left_drive  <= calc_left;
            r_right_drive <= calc_right;
            r_node        <= calc_node;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wall_class   = r_class;
    assign o_left_drive   = r_left_drive;
    assign o_right_drive  = r_right_drive;
    assign o_node_entered = r_node;

endmodule

FILE: design/wfsc_checker.sv
// Port-level checker for the steering classifier, bound to the top level.
`include "wall_follow_steering_classifier_defines.svh"

module wfsc_checker
    import wfsc_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [CLASS_W-1:0]        o_wall_class,
    input logic signed [DRIVE_W-1:0] o_left_drive,
    input logic signed [DRIVE_W-1:0] o_right_drive,
    input logic                      o_node_entered
);

    `WFSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_wall_class) && $stable(o_left_drive) &&
        $stable(o_right_drive) && $stable(o_node_entered))

    // a front wall stops both wheels and always marks a node
    `WFSC_ASSERT_NOW(a_front_node, i_clk, i_rst_n, o_out_valid && (o_wall_class == CLASS_FRONT),
        o_node_entered && (o_left_drive == 12'sd0) && (o_right_drive == 12'sd0))

    `WFSC_ASSERT_NOW(a_none_spin, i_clk, i_rst_n, o_out_valid && (o_wall_class == CLASS_NONE),
        (o_left_drive == -SPIN_SPEED) && (o_right_drive == SPIN_SPEED))

    // between two walls the wheel speeds always differ by twice the base speed
    `WFSC_ASSERT_NOW(a_two_base, i_clk, i_rst_n, o_out_valid && (o_wall_class == CLASS_TWO),
        (o_right_drive - o_left_drive) == 12'sd140)

endmodule

bind wall_follow_steering_classifier wfsc_checker u_wfsc_checker (.*);
